/* design/sgs_pkg.sv */
// package for the spatial sir grid step unit
// grid geometry, codes, shared types and the long division digit step
// no dependencies
package sgs_pkg;

   localparam int GRID_SIDE  = 16;
   localparam int CELLS      = GRID_SIDE * GRID_SIDE;
   localparam int ADDR_W     = $clog2(CELLS);
   localparam int FEED_LAST  = CELLS + GRID_SIDE;
   localparam int FEED_W     = $clog2(FEED_LAST + 1);
   localparam int TAPS       = 2 * GRID_SIDE + 2;
   localparam int POPULATION = 500;
   localparam int VAL_W      = 24;
   localparam int REC_W      = 28;
   localparam int CSR_W      = 16;
   localparam int PHI_W      = 13;
   localparam logic [PHI_W-1:0] PHI_ONE = 13'd4096;
   localparam logic [VAL_W-1:0] VAL_MAX = '1;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_STEP  = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_R0    = 2'd0,
      CSR_RATE  = 2'd1,
      CSR_PHI   = 2'd2,
      CSR_STEPH = 2'd3
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_STEP = 3'b100
   } state_type;

   typedef struct packed {
      logic [PHI_W-1:0] phi;
      logic [31:0]      c_inf;
      logic [31:0]      k_rec;
   } coef_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [VAL_W-1:0]  s;
      logic [VAL_W-1:0]  i;
      logic [VAL_W-1:0]  r;
      logic [REC_W-1:0]  rec;
   } carry_type;

   // eight restoring division steps, returns {remainder, quotient byte}
   function automatic logic [16:0] div8(logic [8:0] rem_in, logic [7:0] digits,
                                        logic [8:0] divisor);
      logic [9:0] tmp;
      logic [8:0] rem;
      logic [7:0] q;
      rem = rem_in;
      q   = '0;
      for (int b = 7; b >= 0; b--) begin
         tmp = {rem, digits[b]};
         if (tmp >= {1'b0, divisor}) begin
            tmp  = tmp - {1'b0, divisor};
            q[b] = 1'b1;
         end
         rem = tmp[8:0];
      end
      return {rem, q};
   endfunction

endpackage

/* design/sgs_cell.sv */
// one link of the infected snapshot chain
// holds one I value and passes it on when the chain shifts; uses sgs_pkg
module sgs_cell (
   input  logic                     clock,
   input  logic                     shift,
   input  logic [sgs_pkg::VAL_W-1:0] d,
   output logic [sgs_pkg::VAL_W-1:0] q
);
   import sgs_pkg::*;

   logic [VAL_W-1:0] val_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         val_ff <= d;
      end
   end

   assign q = val_ff;
endmodule

/* design/sgs_window.sv */
// moore neighbourhood window built from a chain of sgs_cell links
// gives the eight neighbour I values and their edge mask; uses sgs_pkg
module sgs_window (
   input  logic                       clock,
   input  logic                       shift,
   input  logic [sgs_pkg::VAL_W-1:0]  new_val,
   input  logic [sgs_pkg::ADDR_W-1:0] center,
   output logic [7:0][sgs_pkg::VAL_W-1:0] nbr,
   output logic [7:0]                 nbr_mask,
   output logic [sgs_pkg::VAL_W-1:0]  center_i
);
   import sgs_pkg::*;

   logic [TAPS-1:0][VAL_W-1:0] tap;
   logic [TAPS:0][VAL_W-1:0]   w;
   logic top, bot, lft, rgt;

   assign w[0] = new_val;

   for (genvar k = 0; k < TAPS; k++) begin : g_chain
      sgs_cell u_cell (
         .clock (clock),
         .shift (shift),
         .d     (w[k]),
         .q     (tap[k])
      );
      assign w[k+1] = tap[k];
   end

   always_comb begin
      top = (center / GRID_SIDE) != 0;
      bot = (center / GRID_SIDE) != ADDR_W'(GRID_SIDE - 1);
      lft = (center % GRID_SIDE) != 0;
      rgt = (center % GRID_SIDE) != ADDR_W'(GRID_SIDE - 1);
      nbr[0] = w[0];
      nbr[1] = w[1];
      nbr[2] = w[2];
      nbr[3] = w[GRID_SIDE];
      nbr[4] = w[GRID_SIDE + 2];
      nbr[5] = w[2 * GRID_SIDE];
      nbr[6] = w[2 * GRID_SIDE + 1];
      nbr[7] = w[2 * GRID_SIDE + 2];
      nbr_mask[0] = bot & rgt;
      nbr_mask[1] = bot;
      nbr_mask[2] = bot & lft;
      nbr_mask[3] = rgt;
      nbr_mask[4] = lft;
      nbr_mask[5] = top & rgt;
      nbr_mask[6] = top;
      nbr_mask[7] = top & lft;
   end

   assign center_i = w[GRID_SIDE + 1];
endmodule

/* design/sgs_update.sv */
// pipelined euler update of one cell per cycle
// weighted infection, staged divisions, saturation; uses sgs_pkg
module sgs_update (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  sgs_pkg::carry_type            in_car,
   input  logic [7:0][sgs_pkg::VAL_W-1:0] nbr,
   input  logic [7:0]                    nbr_mask,
   input  sgs_pkg::coef_type             coef,
   output logic                          wb_valid,
   output logic [sgs_pkg::ADDR_W-1:0]    wb_addr,
   output logic [sgs_pkg::VAL_W-1:0]     wb_s,
   output logic [sgs_pkg::VAL_W-1:0]     wb_i,
   output logic [sgs_pkg::VAL_W-1:0]     wb_r
);
   import sgs_pkg::*;

   localparam int DN = 6;
   localparam int DP = 5;

   logic [26:0] sum_c;
   logic [3:0]  n_c;
   logic [15:0] a_c;

   logic        v1_ff;
   carry_type   c1_ff;
   carry_type   c1_rec_c;
   logic [26:0] sum1_ff;
   logic [15:0] a1_ff;
   logic [3:0]  d1_ff;

   logic        v2_ff;
   carry_type   c2_ff;
   logic [39:0] ma2_ff, mb2_ff;
   logic [3:0]  d2_ff;

   logic [DN:0]            nv_ff;
   carry_type              nc_ff [DN+1];
   logic [DN:0][47:0]      nx_ff;
   logic [DN:0][8:0]       nr_ff;
   logic [DN:0][3:0]       nd_ff;
   logic [DN-1:0][16:0]    nq_c;

   logic        vp_ff;
   carry_type   cp_ff;
   logic [41:0] phi_ff, plo_ff;

   logic [DP:0]         pv_ff;
   carry_type           pc_ff [DP+1];
   logic [DP:0][39:0]   px_ff;
   logic [DP:0][8:0]    pr_ff;
   logic [DP-1:0][16:0] pq_c;
   logic [59:0]         x60_c;

   logic        vm_ff;
   carry_type   cm_ff;
   logic [33:0] inf_ff;
   logic [57:0] prod_c;

   logic [34:0] isum_c;
   logic [34:0] idif_c;
   logic [28:0] rsum_c;

   always_comb begin
      sum_c = '0;
      n_c   = '0;
      for (int k = 0; k < 8; k++) begin
         if (nbr_mask[k]) begin
            sum_c = sum_c + 27'(nbr[k]);
            n_c   = n_c + 4'd1;
         end
      end
      a_c = 16'({1'b0, n_c + 4'd1, 12'b0} - 17'(17'(coef.phi) * 17'(n_c)));
   end

   always_comb begin
      c1_rec_c     = c1_ff;
      c1_rec_c.rec = REC_W'((56'(coef.k_rec) * 56'(c1_ff.i)) >> 28);
      for (int k = 0; k < DN; k++) begin
         nq_c[k] = div8(nr_ff[k], nx_ff[k][47:40], {5'b0, nd_ff[k]});
      end
      for (int k = 0; k < DP; k++) begin
         pq_c[k] = div8(pr_ff[k], px_ff[k][39:32], 9'(POPULATION));
      end
      x60_c  = {phi_ff, 18'b0} + 60'(plo_ff);
      prod_c = 58'(px_ff[DP][25:0]) * 58'(coef.c_inf);
      isum_c = 35'(cm_ff.i) + 35'(inf_ff);
      idif_c = isum_c - 35'(cm_ff.rec);
      rsum_c = 29'(cm_ff.r) + 29'(cm_ff.rec);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         nv_ff <= '0;
         vp_ff <= 1'b0;
         pv_ff <= '0;
         vm_ff <= 1'b0;
         wb_valid <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         nv_ff[0] <= v2_ff;
         for (int k = 0; k < DN; k++) begin
            nv_ff[k+1] <= nv_ff[k];
         end
         vp_ff <= nv_ff[DN];
         pv_ff[0] <= vp_ff;
         for (int k = 0; k < DP; k++) begin
            pv_ff[k+1] <= pv_ff[k];
         end
         vm_ff <= pv_ff[DP];
         wb_valid <= vm_ff;
      end
   end

   always_ff @(posedge clock) begin
      c1_ff   <= in_car;
      sum1_ff <= sum_c;
      a1_ff   <= a_c;
      d1_ff   <= n_c + 4'd1;

      c2_ff     <= c1_rec_c;
      ma2_ff    <= 40'(a1_ff) * 40'(c1_ff.i);
      mb2_ff    <= 40'(coef.phi) * 40'(sum1_ff);
      d2_ff     <= d1_ff;

      nc_ff[0] <= c2_ff;
      nx_ff[0] <= 48'(41'(ma2_ff) + 41'(mb2_ff));
      nr_ff[0] <= '0;
      nd_ff[0] <= d2_ff;
      for (int k = 0; k < DN; k++) begin
         nc_ff[k+1] <= nc_ff[k];
         nx_ff[k+1] <= {nx_ff[k][39:0], nq_c[k][7:0]};
         nr_ff[k+1] <= nq_c[k][16:8];
         nd_ff[k+1] <= nd_ff[k];
      end

      cp_ff  <= nc_ff[DN];
      phi_ff <= 42'(nc_ff[DN].s) * 42'(nx_ff[DN][35:18]);
      plo_ff <= 42'(nc_ff[DN].s) * 42'(nx_ff[DN][17:0]);

      pc_ff[0] <= cp_ff;
      px_ff[0] <= 40'(x60_c[59:26]);
      pr_ff[0] <= '0;
      for (int k = 0; k < DP; k++) begin
         pc_ff[k+1] <= pc_ff[k];
         px_ff[k+1] <= {px_ff[k][31:0], pq_c[k][7:0]};
         pr_ff[k+1] <= pq_c[k][16:8];
      end

      cm_ff  <= pc_ff[DP];
      inf_ff <= prod_c[57:24];

      wb_addr <= cm_ff.addr;
      wb_s    <= (34'(cm_ff.s) > inf_ff) ? VAL_W'(34'(cm_ff.s) - inf_ff) : '0;
      if (isum_c < 35'(cm_ff.rec)) begin
         wb_i <= '0;
      end else if (idif_c > 35'(VAL_MAX)) begin
         wb_i <= VAL_MAX;
      end else begin
         wb_i <= idif_c[VAL_W-1:0];
      end
      wb_r <= (rsum_c > 29'(VAL_MAX)) ? VAL_MAX : rsum_c[VAL_W-1:0];
   end
endmodule

/* design/spatial_sir_euler_grid_step_unit.sv */
// spatial sir grid step unit, top level with cell stores and control
// depends on sgs_pkg, sgs_window, sgs_update
// A write or an unknown operation answers in the cycle after the request; a read
// passes the store read register and then the response register. A step streams
// all 256 cells through the neighbourhood chain and the update pipeline, one cell
// per cycle, and answers once the last cell is written back, after the feed
// positions (the 256 cells plus the 17 cell lookahead of the window), the store
// read, the update pipeline and the response register; the rate is set by the single read port
// of each cell store. Requests are taken one at a time; a new one is taken at
// the earliest in the cycle that the previous response leaves.
module spatial_sir_euler_grid_step_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_cell_index,
   input  logic [23:0] req_susceptible_in,
   input  logic [23:0] req_infected_in,
   input  logic [23:0] req_recovered_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_op_done,
   output logic [23:0] rsp_susceptible_out,
   output logic [23:0] rsp_infected_out,
   output logic [23:0] rsp_recovered_out,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import sgs_pkg::*;

   logic [VAL_W-1:0] s_mem [CELLS];
   logic [VAL_W-1:0] i_mem [CELLS];
   logic [VAL_W-1:0] r_mem [CELLS];
   logic [VAL_W-1:0] s_rd_ff, i_rd_ff, r_rd_ff;

   logic [15:0]      r0_ff, rate_ff, h_ff;
   logic [PHI_W-1:0] phi_ff;
   logic [31:0]      r0r_ff;
   coef_type         coef_ff;

   state_type        state_ff, state_in;
   logic [FEED_W-1:0] feed_ff, feed_in;
   logic             feeding_ff, feeding_in;
   logic             rd_valid_ff;
   logic [FEED_W-1:0] rd_feed_ff;
   logic             rd_ok_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_op_ff, rsp_op_in;
   logic [VAL_W-1:0] rsp_s_ff, rsp_s_in, rsp_i_ff, rsp_i_in, rsp_r_ff, rsp_r_in;

   logic              accept;
   logic              req_ok;
   logic [ADDR_W-1:0] req_addr;
   logic [ADDR_W-1:0] i_addr, sr_addr;
   logic [ADDR_W-1:0] center;
   logic              ctr_valid;
   carry_type         ctr_car;
   logic [7:0][VAL_W-1:0] nbr;
   logic [7:0]        nbr_mask;
   logic [VAL_W-1:0]  ctr_i;
   logic              wb_valid;
   logic [ADDR_W-1:0] wb_addr;
   logic [VAL_W-1:0]  wb_s, wb_i, wb_r;
   logic              step_done;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign req_addr  = req_cell_index[ADDR_W-1:0];
   assign req_ok    = 9'(req_cell_index) < 9'(CELLS);

   // configuration and derived step constants
   always_ff @(posedge clock) begin
      if (reset) begin
         r0_ff   <= 16'd12288;
         rate_ff <= 16'd819;
         phi_ff  <= 13'd2048;
         h_ff    <= 16'd6554;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_R0:    r0_ff   <= csr_wdata;
            CSR_RATE:  rate_ff <= csr_wdata;
            CSR_PHI:   phi_ff  <= csr_wdata[PHI_W-1:0];
            CSR_STEPH: h_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      r0r_ff        <= 32'(r0_ff) * 32'(rate_ff);
      coef_ff.c_inf <= 32'((48'(r0r_ff) * 48'(h_ff)) >> 16);
      coef_ff.k_rec <= 32'(rate_ff) * 32'(h_ff);
      coef_ff.phi   <= (phi_ff > PHI_ONE) ? PHI_ONE : phi_ff;
   end

   // cell stores
   assign i_addr  = (state_ff == ST_STEP) ? feed_ff[ADDR_W-1:0] : req_addr;
   assign sr_addr = (state_ff == ST_STEP) ? ADDR_W'(feed_ff - FEED_W'(GRID_SIDE + 1))
                                          : req_addr;

   always_ff @(posedge clock) begin
      s_rd_ff <= s_mem[sr_addr];
      r_rd_ff <= r_mem[sr_addr];
      i_rd_ff <= i_mem[i_addr];
      if (wb_valid) begin
         s_mem[wb_addr] <= wb_s;
         i_mem[wb_addr] <= wb_i;
         r_mem[wb_addr] <= wb_r;
      end else if (accept && req_operation == OP_WRITE && req_ok) begin
         s_mem[req_addr] <= req_susceptible_in;
         i_mem[req_addr] <= req_infected_in;
         r_mem[req_addr] <= req_recovered_in;
      end
   end

   // step streaming
   assign center    = ADDR_W'(rd_feed_ff - FEED_W'(GRID_SIDE + 1));
   assign ctr_valid = rd_valid_ff && (rd_feed_ff >= FEED_W'(GRID_SIDE + 1));

   sgs_window u_window (
      .clock    (clock),
      .shift    (rd_valid_ff),
      .new_val  (i_rd_ff),
      .center   (center),
      .nbr      (nbr),
      .nbr_mask (nbr_mask),
      .center_i (ctr_i)
   );

   always_comb begin
      ctr_car.addr = center;
      ctr_car.s    = s_rd_ff;
      ctr_car.i    = ctr_i;
      ctr_car.r    = r_rd_ff;
      ctr_car.rec  = '0;
   end

   sgs_update u_update (
      .clock    (clock),
      .reset    (reset),
      .in_valid (ctr_valid),
      .in_car   (ctr_car),
      .nbr      (nbr),
      .nbr_mask (nbr_mask),
      .coef     (coef_ff),
      .wb_valid (wb_valid),
      .wb_addr  (wb_addr),
      .wb_s     (wb_s),
      .wb_i     (wb_i),
      .wb_r     (wb_r)
   );

   assign step_done = wb_valid && (wb_addr == ADDR_W'(CELLS - 1));

   // control
   always_comb begin
      state_in     = state_ff;
      feed_in      = feed_ff;
      feeding_in   = feeding_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_op_in    = rsp_op_ff;
      rsp_s_in     = rsp_s_ff;
      rsp_i_in     = rsp_i_ff;
      rsp_r_in     = rsp_r_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_op_in = req_operation;
               rsp_s_in  = '0;
               rsp_i_in  = '0;
               rsp_r_in  = '0;
               case (req_operation)
                  OP_READ: state_in = ST_READ;
                  OP_STEP: begin
                     state_in   = ST_STEP;
                     feed_in    = '0;
                     feeding_in = 1'b1;
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         ST_READ: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            if (rd_ok_ff) begin
               rsp_s_in = s_rd_ff;
               rsp_i_in = i_rd_ff;
               rsp_r_in = r_rd_ff;
            end
         end
         ST_STEP: begin
            if (feeding_ff) begin
               feed_in = feed_ff + 1'b1;
               if (feed_ff == FEED_W'(FEED_LAST)) begin
                  feeding_in = 1'b0;
               end
            end
            if (step_done) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         feed_ff      <= '0;
         feeding_ff   <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         feed_ff      <= feed_in;
         feeding_ff   <= feeding_in;
         rd_valid_ff  <= feeding_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_feed_ff <= feed_ff;
      rd_ok_ff   <= req_ok;
      rsp_op_ff  <= rsp_op_in;
      rsp_s_ff   <= rsp_s_in;
      rsp_i_ff   <= rsp_i_in;
      rsp_r_ff   <= rsp_r_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_op_done         = rsp_op_ff;
   assign rsp_susceptible_out = rsp_s_ff;
   assign rsp_infected_out    = rsp_i_ff;
   assign rsp_recovered_out   = rsp_r_ff;
endmodule

/* tb/tb_spatial_sir_euler_grid_step_unit.sv */
// testbench for spatial_sir_euler_grid_step_unit: writes, reads and grid steps under
// random idling, checked against a bit-accurate grid model in a small scoreboard class
// depends on sgs_pkg and the unit itself
module tb_spatial_sir_euler_grid_step_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import sgs_pkg::*;

   typedef struct {
      op_type           op;
      logic [VAL_W-1:0] s;
      logic [VAL_W-1:0] i;
      logic [VAL_W-1:0] r;
   } rsp_item_type;

   class grid_scoreboard_type;
      logic [VAL_W-1:0] s_mem [CELLS];
      logic [VAL_W-1:0] i_mem [CELLS];
      logic [VAL_W-1:0] r_mem [CELLS];
      logic [15:0]      r0, rate, h;
      logic [PHI_W-1:0] phi;
      rsp_item_type     pending [$];
      int               errors;
      int               reads, steps, writes;

      function new();
         r0 = 16'd12288; rate = 16'd819; phi = 13'd2048; h = 16'd6554;
         errors = 0; reads = 0; steps = 0; writes = 0;
         foreach (s_mem[k]) begin
            s_mem[k] = '0; i_mem[k] = '0; r_mem[k] = '0;
         end
      endfunction

      function void set_reg(csr_type idx, logic [15:0] val);
         case (idx)
            CSR_R0:    r0 = val;
            CSR_RATE:  rate = val;
            CSR_PHI:   phi = val[PHI_W-1:0];
            CSR_STEPH: h = val;
            default: ;
         endcase
      endfunction

      function void advance();
         logic [VAL_W-1:0] snap [CELLS];
         longint unsigned p, c_inf, k_rec, sum, n, w, j, m, inf, rec, s, iv, rv;
         longint signed   in_new;
         int              row, col, rr, cc;
         p = (phi > PHI_ONE) ? PHI_ONE : phi;
         c_inf = (longint'(r0) * rate * h) >> 16;
         k_rec = longint'(rate) * h;
         foreach (snap[k]) snap[k] = i_mem[k];
         for (int cix = 0; cix < CELLS; cix++) begin
            row = cix / GRID_SIDE;
            col = cix % GRID_SIDE;
            sum = 0; n = 0;
            for (int dr = -1; dr <= 1; dr++)
               for (int dc = -1; dc <= 1; dc++) begin
                  rr = row + dr; cc = col + dc;
                  if (!(dr == 0 && dc == 0) && rr >= 0 && rr < GRID_SIDE &&
                      cc >= 0 && cc < GRID_SIDE) begin
                     sum += snap[rr * GRID_SIDE + cc];
                     n++;
                  end
               end
            s = s_mem[cix]; iv = i_mem[cix]; rv = r_mem[cix];
            w = ((n + 1) * 4096 - p * n) * iv + p * sum;
            j = w / (n + 1);
            m = ((s * j) / POPULATION) >> 26;
            if (m != 0 && c_inf > 64'hFFFF_FFFF_FFFF_FFFF / m) inf = 64'd1 << 40;
            else begin
               inf = (m * c_inf) >> 24;
               if (inf > (64'd1 << 40)) inf = 64'd1 << 40;
            end
            rec = (k_rec * iv) >> 28;
            s_mem[cix] = (s > inf) ? VAL_W'(s - inf) : '0;
            in_new = longint'(iv) + longint'(inf) - longint'(rec);
            if (in_new < 0) in_new = 0;
            if (in_new > longint'(VAL_MAX)) in_new = longint'(VAL_MAX);
            i_mem[cix] = VAL_W'(in_new);
            rv += rec;
            r_mem[cix] = (rv > VAL_MAX) ? VAL_MAX : VAL_W'(rv);
         end
      endfunction

      function void note_request(op_type op, logic [7:0] idx, logic [VAL_W-1:0] s,
                                 logic [VAL_W-1:0] i, logic [VAL_W-1:0] r);
         rsp_item_type e;
         e.op = op; e.s = '0; e.i = '0; e.r = '0;
         case (op)
            OP_WRITE: begin
               s_mem[idx] = s; i_mem[idx] = i; r_mem[idx] = r; writes++;
            end
            OP_STEP: begin
               advance(); steps++;
            end
            OP_READ: begin
               e.s = s_mem[idx]; e.i = i_mem[idx]; e.r = r_mem[idx]; reads++;
            end
            default: ;
         endcase
         pending.push_back(e);
      endfunction

      function void check_response(logic [1:0] op, logic [VAL_W-1:0] s,
                                   logic [VAL_W-1:0] i, logic [VAL_W-1:0] r);
         rsp_item_type e;
         if (pending.size() == 0) begin
            $display("%0t: response with nothing expected, op %0d", $time, op);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (op !== e.op) begin
            $display("%0t: op_done expected %0d actual %0d", $time, e.op, op); errors++;
         end
         if (s !== e.s) begin
            $display("%0t: susceptible expected %h actual %h", $time, e.s, s); errors++;
         end
         if (i !== e.i) begin
            $display("%0t: infected expected %h actual %h", $time, e.i, i); errors++;
         end
         if (r !== e.r) begin
            $display("%0t: recovered expected %h actual %h", $time, e.r, r); errors++;
         end
      endfunction
   endclass

   logic        clock, reset;
   logic        req_valid, req_ready;
   logic [1:0]  req_operation;
   logic [7:0]  req_cell_index;
   logic [23:0] req_susceptible_in, req_infected_in, req_recovered_in;
   logic        rsp_valid, rsp_ready;
   logic [1:0]  rsp_op_done;
   logic [23:0] rsp_susceptible_out, rsp_infected_out, rsp_recovered_out;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   grid_scoreboard_type sb;
   int send_idle_pct, rsp_stall_pct;

   spatial_sir_euler_grid_step_unit uut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("timeout");
      $display("** spatial_sir_euler_grid_step_unit: FAILED **");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_op_done, rsp_susceptible_out, rsp_infected_out,
                           rsp_recovered_out);
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic send(op_type op, logic [7:0] idx, logic [23:0] s, logic [23:0] i,
                       logic [23:0] r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_operation      <= op;
      req_cell_index     <= idx;
      req_susceptible_in <= s;
      req_infected_in    <= i;
      req_recovered_in   <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(op, idx, s, i, r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(csr_type idx, logic [15:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
   endtask

   task automatic set_params(logic [15:0] r0, logic [15:0] rate, logic [15:0] phi,
                             logic [15:0] h);
      write_reg(CSR_R0, r0);
      write_reg(CSR_RATE, rate);
      write_reg(CSR_PHI, phi);
      write_reg(CSR_STEPH, h);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [23:0] rand_val();
      case ($urandom_range(5))
         0: return '0;
         1: return VAL_MAX;
         2: return 24'($urandom_range(16383, 0));
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic random_request();
      int pick;
      pick = $urandom_range(99);
      if (pick < 42) send(OP_WRITE, 8'($urandom), rand_val(), rand_val(), rand_val());
      else if (pick < 52) send(OP_STEP, 8'($urandom), rand_val(), rand_val(), rand_val());
      else if (pick < 95) send(OP_READ, 8'($urandom), rand_val(), rand_val(), rand_val());
      else send(OP_NONE, 8'($urandom), rand_val(), rand_val(), rand_val());
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0; req_operation = OP_WRITE; req_cell_index = '0;
      req_susceptible_in = '0; req_infected_in = '0; req_recovered_in = '0;
      csr_write_enable = 1'b0; csr_index = CSR_R0; csr_wdata = '0;
      send_idle_pct = 0; rsp_stall_pct = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill every cell before any read or step
      for (int k = 0; k < CELLS; k++)
         send(OP_WRITE, 8'(k), 24'($urandom_range(16383 * 500, 16383 * 400)),
              24'($urandom_range(16383 * 20, 0)), 24'($urandom_range(16383, 0)));

      // directed: extremes, corners, every operation
      send(OP_WRITE, 8'd0, VAL_MAX, VAL_MAX, VAL_MAX);
      send(OP_WRITE, 8'd255, '0, '0, '0);
      send(OP_WRITE, 8'd15, VAL_MAX, '0, VAL_MAX);
      send(OP_WRITE, 8'd240, '0, VAL_MAX, '0);
      send(OP_READ, 8'd0, '0, '0, '0);
      send(OP_READ, 8'd255, VAL_MAX, VAL_MAX, VAL_MAX);
      send(OP_NONE, 8'd7, VAL_MAX, VAL_MAX, VAL_MAX);
      send(OP_STEP, 8'd0, '0, '0, '0);
      send(OP_READ, 8'd0, '0, '0, '0);
      send(OP_READ, 8'd15, '0, '0, '0);
      send(OP_READ, 8'd240, '0, '0, '0);
      send(OP_READ, 8'd255, '0, '0, '0);
      send(OP_READ, 8'd17, '0, '0, '0);
      drain();

      // huge products and mixing above one
      set_params(16'hFFFF, 16'hFFFF, 16'h1FFF, 16'hFFFF);
      send(OP_STEP, 8'd0, '0, '0, '0);
      send(OP_READ, 8'd1, '0, '0, '0);
      send(OP_READ, 8'd100, '0, '0, '0);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 59; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 59; end
            default: begin send_idle_pct = 30; rsp_stall_pct = 30; end
         endcase
         case (ph)
            0: set_params(16'd12288, 16'd819, 16'd2048, 16'd6554);
            1: set_params('0, '0, '0, '0);
            2: set_params(16'd4096, 16'd4096, 16'd4096, 16'd32768);
            3: set_params(16'hFFFF, 16'hFFFF, 16'd4097, 16'hFFFF);
            default: set_params(16'($urandom), 16'($urandom), 16'($urandom_range(8191)),
                                16'($urandom));
         endcase
         for (int k = 0; k < 190; k++) begin
            random_request();
            if (ph == 1 && k == 100) begin
               // hold off until everything outstanding has come back
               req_valid <= 1'b0;
               @(posedge clock);
               while (sb.pending.size() != 0) @(posedge clock);
            end
         end
         drain();
      end

      repeat (50) @(posedge clock);
      $display("covered %0d writes, %0d reads, %0d grid steps over 8 parameter sets",
               sb.writes, sb.reads, sb.steps);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("** spatial_sir_euler_grid_step_unit: PASSED **");
      else
         $display("** spatial_sir_euler_grid_step_unit: FAILED **");
      $finish;
   end
endmodule

/* spatial_sir_euler_grid_step_unit.f */
design/sgs_pkg.sv
design/sgs_cell.sv
design/sgs_window.sv
design/sgs_update.sv
design/spatial_sir_euler_grid_step_unit.sv
tb/tb_spatial_sir_euler_grid_step_unit.sv
